>>> design/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsd_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_RSV       = 3'd1;
	localparam logic [2:0] ERR_OPCODE    = 3'd2;
	localparam logic [2:0] ERR_CONT      = 3'd3;
	localparam logic [2:0] ERR_CTRL_LEN  = 3'd4;
	localparam logic [2:0] ERR_CLOSE_ONE = 3'd5;

	// Opcodes.
	localparam logic [3:0] OP_CONT       = 4'h0;
	localparam logic [3:0] OP_TEXT       = 4'h1;
	localparam logic [3:0] OP_BINARY     = 4'h2;
	localparam logic [3:0] OP_CONN_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING       = 4'h9;
	localparam logic [3:0] OP_PONG       = 4'hA;

	// Length byte codes and the control frame payload limit.
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
	localparam int CTRL_MAX_LEN = 125;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [3:0]  frame_opcode;
		logic        frame_last;
		logic        message_last;
		logic [15:0] close_status;
		logic [2:0]  error_code;
	} wsd_result_t;

	typedef struct packed {
		logic halted;
		logic in_frame;
	} wsd_status_t;

endpackage

>>> design/wsd_byte_if.sv
// Byte stream channel into the deframer.
`timescale 1ns / 1ps
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

>>> design/wsd_frame_if.sv
// Result channel out of the deframer.
`timescale 1ns / 1ps
interface wsd_frame_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [3:0]  frame_opcode;
	logic        frame_last;
	logic        message_last;
	logic [15:0] close_status;
	logic [2:0]  error_code;

	modport source (output valid, output kind, output payload_byte, output frame_opcode,
		output frame_last, output message_last, output close_status, output error_code,
		input ready);
	modport sink (input valid, input kind, input payload_byte, input frame_opcode,
		input frame_last, input message_last, input close_status, input error_code,
		output ready);
endinterface

>>> design/wsd_parser.sv
// Frame header parser and payload unmasking, one byte per accepted transaction.
`timescale 1ns / 1ps
module wsd_parser #(
	parameter int LEN_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           in_byte,
	output logic                 res_valid,
	output wsd_pkg::wsd_result_t res,
	output wsd_pkg::wsd_status_t status
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_START,
		PH_LEN,
		PH_EXT16,
		PH_EXT64,
		PH_KEY,
		PH_STATUS,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic                   fin;
		logic [3:0]             opcode;
		logic                   masked;
		logic [2:0]             hdr_cnt;
		logic [31:0]            key;
		logic [LEN_WIDTH-1:0]   rem;
		logic                   ovf;
		logic [1:0]             mask_idx;
		logic [15:0]            close_st;
		logic                   status_second;
		logic                   cont_open;
		logic                   halted;
	} parse_state_t;

	parse_state_t st_q, st_d;

	logic                 len_done;
	logic                 begin_pay;
	logic [LEN_WIDTH-1:0] len_val;
	logic [LEN_WIDTH-1:0] shifted;
	logic                 ovf_n;
	logic [7:0]           unmasked;
	logic [3:0]           cur_op;
	logic                 is_ctrl;
	logic                 is_data;
	logic [3:0]           b_op;

	assign b_op     = in_byte[3:0];
	assign cur_op   = (st_q.phase == PH_START) ? b_op : st_q.opcode;
	assign unmasked = in_byte ^ st_q.key[{st_q.mask_idx, 3'b000} +: 8];
	assign shifted  = {st_q.rem[LEN_WIDTH-9:0], in_byte};
	assign ovf_n    = st_q.ovf | (|st_q.rem[LEN_WIDTH-1:LEN_WIDTH-8]);
	assign is_ctrl  = (b_op == OP_CONN_CLOSE) || (b_op == OP_PING) || (b_op == OP_PONG);
	assign is_data  = (b_op == OP_TEXT) || (b_op == OP_BINARY);

	always_comb begin
		st_d      = st_q;
		res_valid = 1'b0;
		len_done  = 1'b0;
		begin_pay = 1'b0;
		len_val   = st_q.rem;
		res.kind         = KIND_DATA;
		res.payload_byte = 8'd0;
		res.frame_opcode = cur_op;
		res.frame_last   = 1'b0;
		res.message_last = 1'b0;
		res.close_status = 16'd0;
		res.error_code   = ERR_NONE;

		if (!st_q.halted) begin
			case (st_q.phase)
				PH_START: begin
					st_d.fin           = in_byte[7];
					st_d.opcode        = b_op;
					st_d.masked        = 1'b0;
					st_d.hdr_cnt       = 3'd0;
					st_d.key           = 32'd0;
					st_d.rem           = '0;
					st_d.ovf           = 1'b0;
					st_d.mask_idx      = 2'd0;
					st_d.close_st      = 16'd0;
					st_d.status_second = 1'b0;
					if (in_byte[6:4] != 3'd0) begin
						st_d.halted    = 1'b1;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_RSV;
					end else if (!is_ctrl && !is_data && (b_op != OP_CONT)) begin
						st_d.halted    = 1'b1;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_OPCODE;
					end else if (!is_ctrl &&
						(st_q.cont_open ? is_data : (b_op == OP_CONT))) begin
						st_d.halted    = 1'b1;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_CONT;
					end else begin
						// Control frames may interleave a fragmented message.
						if (!is_ctrl) begin
							st_d.cont_open = ~in_byte[7];
						end
						st_d.phase = PH_LEN;
					end
				end
				PH_LEN: begin
					st_d.masked  = in_byte[7];
					st_d.hdr_cnt = 3'd0;
					st_d.rem     = '0;
					st_d.ovf     = 1'b0;
					if (in_byte[6:0] == LEN_CODE_EXT16) begin
						st_d.phase = PH_EXT16;
					end else if (in_byte[6:0] == LEN_CODE_EXT64) begin
						st_d.phase = PH_EXT64;
					end else begin
						len_done = 1'b1;
						len_val  = LEN_WIDTH'(in_byte[6:0]);
					end
				end
				PH_EXT16, PH_EXT64: begin
					st_d.rem = shifted;
					st_d.ovf = ovf_n;
					if (st_q.hdr_cnt == ((st_q.phase == PH_EXT16) ? 3'd1 : 3'd7)) begin
						// A length that does not fit the counter saturates.
						len_done = 1'b1;
						len_val  = ovf_n ? '1 : shifted;
					end else begin
						st_d.hdr_cnt = st_q.hdr_cnt + 3'd1;
					end
				end
				PH_KEY: begin
					st_d.key[{st_q.hdr_cnt[1:0], 3'b000} +: 8] = in_byte;
					if (st_q.hdr_cnt >= 3'd3) begin
						begin_pay = 1'b1;
					end else begin
						st_d.hdr_cnt = st_q.hdr_cnt + 3'd1;
					end
				end
				PH_STATUS: begin
					st_d.close_st = {st_q.close_st[7:0], unmasked};
					st_d.rem      = st_q.rem - LEN_WIDTH'(1);
					st_d.mask_idx = st_q.mask_idx + 2'd1;
					if (!st_q.status_second) begin
						st_d.status_second = 1'b1;
					end else if (st_q.rem == LEN_WIDTH'(1)) begin
						st_d.phase       = PH_START;
						res_valid        = 1'b1;
						res.kind         = KIND_EMPTY;
						res.frame_last   = 1'b1;
						res.message_last = st_q.fin;
						res.close_status = {st_q.close_st[7:0], unmasked};
					end else begin
						st_d.phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					st_d.rem      = st_q.rem - LEN_WIDTH'(1);
					st_d.mask_idx = st_q.mask_idx + 2'd1;
					res_valid        = 1'b1;
					res.kind         = KIND_DATA;
					res.payload_byte = unmasked;
					res.close_status = st_q.close_st;
					if (st_q.rem == LEN_WIDTH'(1)) begin
						st_d.phase       = PH_START;
						res.frame_last   = 1'b1;
						res.message_last = st_q.fin;
					end
				end
				default: begin
					st_d.phase = PH_START;
				end
			endcase

			if (len_done) begin
				st_d.rem = len_val;
				if (st_q.opcode[3] && (len_val > LEN_WIDTH'(CTRL_MAX_LEN))) begin
					st_d.halted    = 1'b1;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_CTRL_LEN;
				end else if ((st_q.opcode == OP_CONN_CLOSE) &&
					(len_val == LEN_WIDTH'(1))) begin
					st_d.halted    = 1'b1;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_CLOSE_ONE;
				end else if (st_d.masked) begin
					st_d.hdr_cnt = 3'd0;
					st_d.phase   = PH_KEY;
				end else begin
					begin_pay = 1'b1;
				end
			end

			if (begin_pay) begin
				st_d.mask_idx = 2'd0;
				if (len_val == '0) begin
					st_d.phase       = PH_START;
					res_valid        = 1'b1;
					res.kind         = KIND_EMPTY;
					res.frame_last   = 1'b1;
					res.message_last = st_q.fin;
					res.close_status = st_q.close_st;
				end else if (st_q.opcode == OP_CONN_CLOSE) begin
					st_d.status_second = 1'b0;
					st_d.phase         = PH_STATUS;
				end else begin
					st_d.phase = PH_PAYLOAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_START, fin: 1'b0, opcode: 4'd0, masked: 1'b0,
				hdr_cnt: 3'd0, key: 32'd0, rem: '0, ovf: 1'b0, mask_idx: 2'd0,
				close_st: 16'd0, status_second: 1'b0, cont_open: 1'b0, halted: 1'b0};
		end else if (accept) begin
			st_q <= st_d;
		end
	end

	assign status.halted   = st_q.halted;
	assign status.in_frame = (st_q.phase != PH_START);

endmodule

>>> design/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: parser plus a two-entry output buffer.
//
//   channel  | modport | payload                                       | carries
//   stream   | sink    | in_byte                                       | one received byte
//   frame    | source  | kind, payload_byte, frame_opcode, frame_last, | zero or one result
//            |         | message_last, close_status, error_code        | per byte
//
// One byte is taken every cycle while stream is ready; its result is registered.
// The parser state and the output register are the only pipeline; the state loop
// through the length counter decides the clock rate.
// Reset clears the parser to the start of a frame; no clearing pass is needed.
// A skid entry holds one result while frame is stalled, so stream stays ready until
// two results wait. After a protocol error all bytes are taken without results.
`timescale 1ns / 1ps
module websocket_frame_deframer #(
	parameter int LEN_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	wsd_byte_if.sink     stream,
	wsd_frame_if.source  frame
);
	import wsd_pkg::*;

	logic        accept;
	logic        res_valid;
	wsd_result_t res;
	wsd_status_t par_status;

	wsd_result_t main_q;
	wsd_result_t skid_q;
	logic        main_valid_q;
	logic        skid_valid_q;
	logic        push;
	logic        out_fire;

	assign stream.ready = ~skid_valid_q;
	assign accept       = stream.valid & stream.ready;
	assign push         = accept & res_valid;
	assign out_fire     = main_valid_q & frame.ready;

	wsd_parser #(
		.LEN_WIDTH (LEN_WIDTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (stream.in_byte),
		.res_valid (res_valid),
		.res       (res),
		.status    (par_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || out_fire) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || out_fire) begin
			main_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign frame.valid        = main_valid_q;
	assign frame.kind         = main_q.kind;
	assign frame.payload_byte = main_q.payload_byte;
	assign frame.frame_opcode = main_q.frame_opcode;
	assign frame.frame_last   = main_q.frame_last;
	assign frame.message_last = main_q.message_last;
	assign frame.close_status = main_q.close_status;
	assign frame.error_code   = main_q.error_code;

	// The skid entry is only ever filled behind a held main entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry valid without main entry");

	// An error result stops the parser for good.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && (res.kind == KIND_ERROR)) |=> (par_status.halted && !res_valid))
		else $error("parser not halted after error result");

	// A result that ends a frame leaves the parser at the start of the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.frame_last) |=> !par_status.in_frame)
		else $error("parser still inside a frame after its last result");

endmodule
